/* design/fpr_pkg.sv */
package fpr_pkg;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned STAT_W  = 32;

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAT_W-1:0]  stat_t;

  typedef struct packed {
    page_t page_number;
  } ref_item_t;

  typedef struct packed {
    logic   hit;
    logic   evicted_valid;
    page_t  evicted_page;
    count_t occupancy;
    stat_t  hits_so_far;
    stat_t  misses_so_far;
  } result_item_t;

  typedef struct packed {
    count_t frame_capacity;
  } cfg_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } dp_cmd_t;

endpackage

/* design/fpr_chan_if.sv */
interface fpr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/fpr_ctrl.sv */
module fpr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fpr_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/fpr_dp.sv */
module fpr_dp #(
  parameter int unsigned FRAMES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fpr_pkg::dp_cmd_t      cmd_i,
  input  fpr_pkg::page_t        page_i,
  input  logic                  cfg_we_i,
  input  fpr_pkg::count_t       cfg_cap_i,
  output fpr_pkg::result_item_t result_o
);

  localparam int unsigned COUNT_W = fpr_pkg::COUNT_W;
  // capacity register tops out at 31, so frames beyond that are never used
  localparam int unsigned CAP_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned USED    = (FRAMES < CAP_MAX) ? FRAMES : CAP_MAX;
  localparam logic [COUNT_W:0] USED_W = (COUNT_W + 1)'(USED);

  fpr_pkg::page_t  frames_q [USED];
  fpr_pkg::page_t  frames_d [USED];
  fpr_pkg::page_t  page_q;
  fpr_pkg::count_t count_q, count_d;
  fpr_pkg::count_t cap_q;
  fpr_pkg::count_t cap_eff;
  fpr_pkg::stat_t  hits_q, hits_d;
  fpr_pkg::stat_t  misses_q, misses_d;
  logic            hit_q;
  logic [USED-1:0] match;
  logic            append, evict;
  fpr_pkg::result_item_t res_q, res_d;

  always_comb begin
    cap_eff = (cap_q == '0) ? COUNT_W'(1) : cap_q;
    if ({1'b0, cap_eff} > USED_W) begin
      cap_eff = COUNT_W'(USED);
    end
  end

  always_comb begin
    for (int i = 0; i < USED; i++) begin
      match[i] = (COUNT_W'(i) < count_q) && (frames_q[i] == page_q);
    end
  end

  assign append = !hit_q && (count_q < cap_eff);
  assign evict  = !hit_q && !(count_q < cap_eff) && (count_q != '0);

  always_comb begin
    for (int i = 0; i < USED; i++) begin
      frames_d[i] = frames_q[i];
      if (append && (COUNT_W'(i) == count_q)) begin
        frames_d[i] = page_q;
      end else if (evict) begin
        if ((COUNT_W'(i) + COUNT_W'(1)) < count_q) begin
          if (i + 1 < USED) begin
            frames_d[i] = frames_q[(i + 1) % USED];
          end
        end else if ((COUNT_W'(i) + COUNT_W'(1)) == count_q) begin
          frames_d[i] = page_q;
        end
      end
    end
  end

  always_comb begin
    count_d  = append ? count_q + COUNT_W'(1) : count_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    if (hit_q) begin
      if (!(&hits_q)) hits_d = hits_q + fpr_pkg::STAT_W'(1);
    end else begin
      if (!(&misses_q)) misses_d = misses_q + fpr_pkg::STAT_W'(1);
    end
    res_d.hit           = hit_q;
    res_d.evicted_valid = evict;
    res_d.evicted_page  = evict ? frames_q[0] : '0;
    res_d.occupancy     = count_d;
    res_d.hits_so_far   = hits_d;
    res_d.misses_so_far = misses_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= fpr_pkg::CAP_RESET;
      hits_q   <= '0;
      misses_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_cap_i;
      if (cmd_i.update) begin
        count_q  <= count_d;
        hits_q   <= hits_d;
        misses_q <= misses_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) page_q <= page_i;
    if (cmd_i.compare) hit_q <= |match;
    if (cmd_i.update) begin
      res_q <= res_d;
      for (int i = 0; i < USED; i++) begin
        frames_q[i] <= frames_d[i];
      end
    end
  end

  assign result_o = res_q;

endmodule

/* design/fifo_page_replacement.sv */
// FIFO page replacement unit. Each input item is one page reference; each
// reference gives exactly one result: hit flag, the evicted page on a miss at
// capacity (zero otherwise), occupancy after the reference and saturating
// 32-bit hit and miss counts. A reference passes through capture, parallel
// compare against the resident frames and frame/counter update; the result
// sits in an output register, and the next reference is taken while it waits.
// Frames are empty after reset. frame_capacity (reset 16) must be written
// via the config channel only while the unit is idle; this is not enforced.
// Zero acts as one, values over FRAMES as FRAMES. Lowering it below occupancy
// drops nothing: later misses evict the oldest page and keep occupancy.
module fifo_page_replacement #(
  parameter int unsigned FRAMES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpr_chan_if.sink   page_i,
  fpr_chan_if.source result_o,
  fpr_chan_if.sink   cfg_i
);

  fpr_pkg::dp_cmd_t      cmd;
  fpr_pkg::result_item_t result;
  fpr_pkg::ref_item_t    ref_item;
  fpr_pkg::cfg_item_t    cfg_item;

  assign ref_item    = page_i.data;
  assign cfg_item    = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  fpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (page_i.valid),
    .in_ready_o  (page_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd)
  );

  fpr_dp #(
    .FRAMES (FRAMES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .page_i    (ref_item.page_number),
    .cfg_we_i  (cfg_i.valid),
    .cfg_cap_i (cfg_item.frame_capacity),
    .result_o  (result)
  );

  assign result_o.data = result;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FRAME_COUNT = 16;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SEGMENTS    = 10;
  localparam int unsigned SEG_ITEMS   = 110;

  typedef enum logic {ROW_CFG, ROW_REF} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [15:0]           value;
    logic                  typed;
    fpr_pkg::result_item_t lit;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  fpr_chan_if #(.payload_t(fpr_pkg::ref_item_t))    page_ch ();
  fpr_chan_if #(.payload_t(fpr_pkg::result_item_t)) result_ch ();
  fpr_chan_if #(.payload_t(fpr_pkg::cfg_item_t))    cfg_ch ();

  fifo_page_replacement #(
    .FRAMES(FRAME_COUNT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .page_i  (page_ch),
    .result_o(result_ch),
    .cfg_i   (cfg_ch)
  );

  // predicted unit state, oldest page at index 0
  fpr_pkg::page_t  frames [FRAME_COUNT];
  int unsigned     resident;
  fpr_pkg::stat_t  hit_total;
  fpr_pkg::stat_t  miss_total;
  fpr_pkg::count_t capacity;

  fpr_pkg::result_item_t due_results [$];
  int unsigned           failures = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           src_idle;
  int unsigned           snk_idle;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic fpr_pkg::stat_t sat_step(fpr_pkg::stat_t x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic fpr_pkg::result_item_t replace_page(fpr_pkg::page_t p);
    fpr_pkg::result_item_t r;
    int unsigned           lim;
    r   = '0;
    lim = (capacity == 0) ? 1 :
          ((capacity > FRAME_COUNT) ? FRAME_COUNT : capacity);
    for (int i = 0; i < resident; i++) begin
      if (frames[i] == p) r.hit = 1'b1;
    end
    if (r.hit) begin
      hit_total = sat_step(hit_total);
    end else begin
      miss_total = sat_step(miss_total);
      if (resident < lim) begin
        frames[resident] = p;
        resident++;
      end else if (resident > 0) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = frames[0];
        for (int i = 1; i < resident; i++) frames[i-1] = frames[i];
        frames[resident-1] = p;
      end
    end
    r.occupancy     = fpr_pkg::count_t'(resident);
    r.hits_so_far   = hit_total;
    r.misses_so_far = miss_total;
    return r;
  endfunction

  function automatic plan_row_t row_cfg(logic [15:0] v);
    plan_row_t row;
    row.kind  = ROW_CFG;
    row.value = v;
    row.typed = 1'b0;
    row.lit   = '0;
    return row;
  endfunction

  function automatic plan_row_t row_ref(logic [15:0] p);
    plan_row_t row;
    row.kind  = ROW_REF;
    row.value = p;
    row.typed = 1'b0;
    row.lit   = '0;
    return row;
  endfunction

  function automatic plan_row_t row_lit(logic [15:0] p, logic h, logic ev,
                                        fpr_pkg::page_t evp, fpr_pkg::count_t occ,
                                        fpr_pkg::stat_t hs, fpr_pkg::stat_t ms);
    plan_row_t row;
    row = row_ref(p);
    row.typed = 1'b1;
    row.lit.hit           = h;
    row.lit.evicted_valid = ev;
    row.lit.evicted_page  = evp;
    row.lit.occupancy     = occ;
    row.lit.hits_so_far   = hs;
    row.lit.misses_so_far = ms;
    return row;
  endfunction

  // sender side; valid stays high between back-to-back items
  task automatic send_reference(fpr_pkg::page_t p, logic typed,
                                fpr_pkg::result_item_t lit);
    fpr_pkg::result_item_t predicted;
    while ($urandom_range(0, 99) < src_idle) begin
      page_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    page_ch.valid <= 1'b1;
    page_ch.data  <= fpr_pkg::ref_item_t'(p);
    do @(posedge clk_i); while (!page_ch.ready);
    predicted = replace_page(p);
    due_results.insert(due_results.size(), typed ? lit : predicted);
  endtask

  // capacity changes only with nothing in flight
  task automatic write_capacity(fpr_pkg::count_t v);
    page_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= fpr_pkg::cfg_item_t'(v);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    capacity = v;
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp, act);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    fpr_pkg::result_item_t exp;
    fpr_pkg::result_item_t act;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      act = result_ch.data;
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %0h", $time, act);
        failures++;
      end else begin
        exp = due_results.pop_front();
        check_field("hit", exp.hit, act.hit);
        check_field("evicted_valid", exp.evicted_valid, act.evicted_valid);
        check_field("evicted_page", exp.evicted_page, act.evicted_page);
        check_field("occupancy", exp.occupancy, act.occupancy);
        check_field("hits_so_far", exp.hits_so_far, act.hits_so_far);
        check_field("misses_so_far", exp.misses_so_far, act.misses_so_far);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((page_ch.valid && page_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("fifo_page_replacement regression: fail");
      $finish;
    end
  end

  initial begin
    plan_row_t      plan [$];
    int             seg_caps [SEGMENTS];
    fpr_pkg::page_t base;
    fpr_pkg::page_t page;
    int unsigned    span;

    seg_caps = '{16, 1, 0, 31, 17, -1, 2, -1, 15, -1};
    for (int i = 0; i < FRAME_COUNT; i++) frames[i] = '0;
    resident     = 0;
    hit_total    = '0;
    miss_total   = '0;
    capacity     = fpr_pkg::CAP_RESET;
    src_idle     = 28;
    snk_idle     = 54;

    rst_ni          <= 1'b0;
    page_ch.valid   <= 1'b0;
    page_ch.data    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = {
      // page zero must miss on empty frames; reset capacity lets both in
      row_lit(16'h0000, 1'b0, 1'b0, 16'h0000, 5'd1, 32'd0, 32'd1),
      row_lit(16'h0001, 1'b0, 1'b0, 16'h0000, 5'd2, 32'd0, 32'd2),
      // capacity zero acts as one, set below occupancy
      row_cfg(16'd0),
      row_lit(16'h0000, 1'b1, 1'b0, 16'h0000, 5'd2, 32'd1, 32'd2),
      row_lit(16'hFFFF, 1'b0, 1'b1, 16'h0000, 5'd2, 32'd1, 32'd3),
      row_lit(16'h0000, 1'b0, 1'b1, 16'h0001, 5'd2, 32'd1, 32'd4),
      // above the frame count saturates
      row_cfg(16'd31),
      row_ref(16'h0002), row_ref(16'h0004), row_ref(16'h0008), row_ref(16'h0010),
      row_ref(16'h0020), row_ref(16'h0040), row_ref(16'h0080), row_ref(16'h0100),
      row_ref(16'h0200), row_ref(16'h0400), row_ref(16'h0800), row_ref(16'h1000),
      row_ref(16'h2000), row_ref(16'h4000),
      row_ref(16'h8000),
      row_cfg(16'd2),
      row_ref(16'h0001),
      row_ref(16'h4000)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_capacity(fpr_pkg::count_t'(plan[i].value));
      end else begin
        send_reference(plan[i].value, plan[i].typed, plan[i].lit);
      end
    end

    for (int s = 0; s < SEGMENTS; s++) begin
      if (s < 4) begin
        src_idle = 28;
        snk_idle = 54;
      end else if (s < 7) begin
        src_idle = 54;
        snk_idle = 28;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      write_capacity((seg_caps[s] < 0) ? fpr_pkg::count_t'($urandom_range(0, 31)) :
                                         fpr_pkg::count_t'(seg_caps[s]));
      base = fpr_pkg::page_t'($urandom);
      span = $urandom_range(1, 40);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // mostly a small working set so hits and evictions both occur
        if ($urandom_range(0, 99) < 85) begin
          page = base + fpr_pkg::page_t'($urandom_range(0, span));
        end else begin
          page = fpr_pkg::page_t'($urandom);
        end
        send_reference(page, 1'b0, '0);
      end
    end

    page_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (failures == 0) begin
      $display("fifo_page_replacement regression: pass");
    end else begin
      $display("fifo_page_replacement regression: fail");
    end
    $finish;
  end

endmodule
